// ===== rtl/core/mutex_lock_with_fifo_waiters_defines.svh =====
// ============================================================================
// mutex_lock_with_fifo_waiters_defines
// Assertion macros shared by the mutex bank RTL.
// ============================================================================
`ifndef MUTEX_LOCK_WITH_FIFO_WAITERS_DEFINES_SVH
`define MUTEX_LOCK_WITH_FIFO_WAITERS_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define MLFW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define MLFW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mlfw_pkg.sv =====
// ============================================================================
// mlfw_pkg
// Shared types and codes for the mutex bank with FIFO wait queues.
// ============================================================================
`timescale 1ns / 1ps

package mlfw_pkg;

   // Request operation carried on req_tuser
   localparam logic FUNC_WAIT   = 1'b0;
   localparam logic FUNC_SIGNAL = 1'b1;

   // Result status codes
   typedef enum logic [3:0] {
      ST_ACQUIRED        = 4'd0,
      ST_ALREADY_OWNER   = 4'd1,
      ST_ALREADY_BLOCKED = 4'd2,
      ST_BLOCKED         = 4'd3,
      ST_QUEUE_FULL      = 4'd4,
      ST_RELEASED        = 4'd5,
      ST_TRANSFERRED     = 4'd6,
      ST_NOT_OWNER       = 4'd7,
      ST_NOT_LOCKED      = 4'd8,
      ST_INVALID         = 4'd9
   } status_type;

   // New state of the calling process
   typedef enum logic [1:0] {
      CS_RUNNING   = 2'd0,
      CS_BLOCKED   = 2'd1,
      CS_READY     = 2'd2,
      CS_UNCHANGED = 2'd3
   } caller_state_type;

   // Per-queue control: rotate the ring one place, and load the caller id
   // into the tail cell while rotating
   typedef struct packed {
      logic shift;
      logic insert;
   } qctl_type;

endpackage

// ===== rtl/core/mlfw_cell.sv =====
// ============================================================================
// mlfw_cell
// One wait-queue slot: holds a process id and passes it to its neighbor.
// ============================================================================
`timescale 1ns / 1ps

module mlfw_cell #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  mlfw_pkg::qctl_type ctl,
   input  logic             load_sel,
   input  logic [WIDTH-1:0] load_data,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_q
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in_mux;

   // Take the neighbor's id, or the new id when this cell is the insert point
   assign data_in_mux = (ctl.insert && load_sel) ? load_data : data_in;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         data_ff <= data_in_mux;
      end
   end

   assign data_q = data_ff;

endmodule

// ===== rtl/core/mlfw_queue.sv =====
// ============================================================================
// mlfw_queue
// Ring of wait-queue cells for one mutex; cell zero always holds the oldest
// waiter, and a full rotation brings the ring back into order.
// ============================================================================
`timescale 1ns / 1ps

module mlfw_queue #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 8
) (
   input  logic               clock,
   input  mlfw_pkg::qctl_type ctl,
   input  logic [WIDTH-1:0]   ins_pid,
   output logic [WIDTH-1:0]   head_pid
);

   logic [WIDTH-1:0] cell_q [DEPTH];

   // Chain the cells; the tail takes from the head to close the ring
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int NXT = (i == DEPTH - 1) ? 0 : i + 1;

      mlfw_cell #(
         .WIDTH (WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_sel  (i == DEPTH - 1),
         .load_data (ins_pid),
         .data_in   (cell_q[NXT]),
         .data_q    (cell_q[i])
      );
   end

   assign head_pid = cell_q[0];

endmodule

// ===== rtl/core/mutex_lock_with_fifo_waiters.sv =====
// ============================================================================
// mutex_lock_with_fifo_waiters
// Bank of hardware mutexes, each with a FIFO of blocked process ids.
// ============================================================================
// Usage:
//   req channel: req_tuser carries the operation (0 wait, 1 signal),
//   req_tdata the lock id and process id. One rsp transfer follows every
//   req transfer, in order, with status, caller state and current owner.
//   Each request is registered, decided and loaded into the rsp register;
//   a wait on a mutex held by another process also runs a queue scan, in
//   which the ring rotates one cell per cycle past the compare at its head
//   to look for the caller and to find the insert point.
//   The block works on one request at a time and takes the next once it
//   has parked the result in the rsp register.
//   Reset unlocks every mutex and empties every queue; queue cells are not
//   cleared and are read only once written.
//   When the receiver stalls rsp, the block takes one more request and
//   holds its result until the rsp register frees, with req_tready low.
// ============================================================================
`timescale 1ns / 1ps
`include "mutex_lock_with_fifo_waiters_defines.svh"

module mutex_lock_with_fifo_waiters #(
   parameter int NUM_LOCKS   = 3,
   parameter int QUEUE_DEPTH = 8,
   parameter int PID_WIDTH   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] lock_id, [9:2] pid, rest zero
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [3:0] status, [5:4] caller_state,
                                    // [13:6] new_owner, [14] owner_valid
);

   localparam int LOCK_IW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int STEP_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic                          func_ff, func_in;
   logic [1:0]                    lk_ff, lk_in;
   logic [PID_WIDTH-1:0]          pid_ff, pid_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          hit_ff, hit_in;
   mlfw_pkg::status_type          status_ff, status_in;
   mlfw_pkg::caller_state_type    cs_ff, cs_in;
   logic                          held_ff [NUM_LOCKS];
   logic                          held_in [NUM_LOCKS];
   logic [PID_WIDTH-1:0]          owner_ff [NUM_LOCKS];
   logic [PID_WIDTH-1:0]          owner_in [NUM_LOCKS];
   logic [CNT_W-1:0]              count_ff [NUM_LOCKS];
   logic [CNT_W-1:0]              count_in [NUM_LOCKS];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_data_ff, rsp_data_in;

   mlfw_pkg::qctl_type            qctl [NUM_LOCKS];
   logic [PID_WIDTH-1:0]          head_pid [NUM_LOCKS];

   logic                          lk_valid;
   logic [LOCK_IW-1:0]            lk_idx;
   logic [15:0]                   pid_wide;
   logic [PID_WIDTH-1:0]          head_sel;
   logic                          cur_held;
   logic [PID_WIDTH-1:0]          cur_owner;
   logic [CNT_W-1:0]              cur_count;
   logic [CNT_W-1:0]              step_ext;
   logic                          match_now;
   logic                          hit_final;
   logic [15:0]                   owner_wide;
   logic                          out_valid;
   logic [7:0]                    out_owner;

   // Wait queues, one ring of cells per mutex
   for (genvar l = 0; l < NUM_LOCKS; l++) begin : g_queue
      mlfw_queue #(
         .DEPTH (QUEUE_DEPTH),
         .WIDTH (PID_WIDTH)
      ) u_queue (
         .clock    (clock),
         .ctl      (qctl[l]),
         .ins_pid  (pid_ff),
         .head_pid (head_pid[l])
      );
   end

   // Select the addressed mutex
   assign lk_valid   = (5'(lk_ff) < 5'(NUM_LOCKS));
   assign lk_idx     = LOCK_IW'(lk_ff);
   assign pid_wide   = 16'(req_tdata[9:2]);
   assign head_sel   = head_pid[lk_idx];
   assign cur_held   = held_ff[lk_idx];
   assign cur_owner  = owner_ff[lk_idx];
   assign cur_count  = count_ff[lk_idx];
   assign step_ext   = CNT_W'(step_ff);
   assign match_now  = (step_ext < cur_count) && (head_sel == pid_ff);
   assign hit_final  = hit_ff || match_now;

   // Report the owner as it stands after the request
   assign owner_wide = 16'(cur_owner);
   assign out_valid  = lk_valid && cur_held;
   assign out_owner  = out_valid ? owner_wide[7:0] : 8'd0;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      lk_in        = lk_ff;
      pid_in       = pid_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      cs_in        = cs_ff;
      held_in      = held_ff;
      owner_in     = owner_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      for (int l = 0; l < NUM_LOCKS; l++) begin
         qctl[l] = '0;
      end

      case (state_ff)
         // Take a request
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               lk_in    = req_tdata[1:0];
               pid_in   = pid_wide[PID_WIDTH-1:0];
               state_in = S_DECIDE;
            end
         end

         // Settle every case that needs no queue search
         S_DECIDE: begin
            step_in  = '0;
            hit_in   = 1'b0;
            state_in = S_EMIT;
            cs_in    = mlfw_pkg::CS_UNCHANGED;
            if (!lk_valid) begin
               status_in = mlfw_pkg::ST_INVALID;
            end else if (func_ff == mlfw_pkg::FUNC_WAIT) begin
               if (!cur_held) begin
                  held_in[lk_idx]  = 1'b1;
                  owner_in[lk_idx] = pid_ff;
                  status_in        = mlfw_pkg::ST_ACQUIRED;
                  cs_in            = mlfw_pkg::CS_RUNNING;
               end else if (cur_owner == pid_ff) begin
                  status_in = mlfw_pkg::ST_ALREADY_OWNER;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (!cur_held) begin
                  status_in = mlfw_pkg::ST_NOT_LOCKED;
               end else if (cur_owner != pid_ff) begin
                  status_in = mlfw_pkg::ST_NOT_OWNER;
               end else if (cur_count == '0) begin
                  held_in[lk_idx]  = 1'b0;
                  owner_in[lk_idx] = '0;
                  status_in        = mlfw_pkg::ST_RELEASED;
                  cs_in            = mlfw_pkg::CS_READY;
               end else begin
                  // Hand over to the oldest waiter and drop it from the ring
                  owner_in[lk_idx]    = head_sel;
                  qctl[lk_idx].shift  = 1'b1;
                  count_in[lk_idx]    = cur_count - CNT_W'(1);
                  status_in           = mlfw_pkg::ST_TRANSFERRED;
                  cs_in               = mlfw_pkg::CS_READY;
               end
            end
         end

         // Rotate the ring once around, compare at the head, insert at the tail
         S_SCAN: begin
            qctl[lk_idx].shift = 1'b1;
            if ((step_ext == cur_count) && !hit_ff) begin
               qctl[lk_idx].insert = 1'b1;
            end
            hit_in  = hit_final;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUEUE_DEPTH - 1)) begin
               state_in = S_EMIT;
               cs_in    = mlfw_pkg::CS_UNCHANGED;
               if (hit_final) begin
                  status_in = mlfw_pkg::ST_ALREADY_BLOCKED;
               end else if (cur_count == CNT_W'(QUEUE_DEPTH)) begin
                  status_in = mlfw_pkg::ST_QUEUE_FULL;
               end else begin
                  count_in[lk_idx] = cur_count + CNT_W'(1);
                  status_in        = mlfw_pkg::ST_BLOCKED;
                  cs_in            = mlfw_pkg::CS_BLOCKED;
               end
            end
         end

         // Load the result once the rsp register is free
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, out_valid, out_owner, cs_ff, status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LOCKS; l++) begin
            held_ff[l]  <= 1'b0;
            owner_ff[l] <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         owner_ff     <= owner_in;
         count_ff     <= count_in;
      end
      func_ff     <= func_in;
      lk_ff       <= lk_in;
      pid_ff      <= pid_in;
      step_ff     <= step_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      cs_ff       <= cs_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   `MLFW_ASSERT_NEXT(a_scan_ends, (state_ff == S_SCAN) && (step_ff == STEP_W'(QUEUE_DEPTH - 1)),
      state_ff == S_EMIT, "queue scan did not end after one full rotation")
   `MLFW_ASSERT_NOW(a_count_bound, (state_ff == S_EMIT) && lk_valid,
      cur_count <= CNT_W'(QUEUE_DEPTH), "wait queue count above depth")
   `MLFW_ASSERT_NOW(a_free_empty, (state_ff == S_EMIT) && lk_valid && !cur_held,
      cur_count == '0, "free mutex has waiters")
   `MLFW_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready,
      !req_tready, "second request taken while one is in progress")

endmodule

// ===== bench/mutex_lock_with_fifo_waiters_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mutex_lock_with_fifo_waiters_test
// Self-checking bench for the mutex bank with FIFO wait queues. Requests go
// in on the req stream and every response is checked field by field against
// a lock-state predictor kept inside the bench. Directed cases hit each
// outcome, then owner-aware random traffic with random gaps on both sides,
// a long response hold-off backing up the request side, then gapless traffic.
// ============================================================================

module mutex_lock_with_fifo_waiters_test;

   localparam int NUM_LOCKS   = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 3 + 8;

   // Lock indexes
   localparam logic [1:0] LOCK_USER_IN  = 2'd0;
   localparam logic [1:0] LOCK_USER_OUT = 2'd1;
   localparam logic [1:0] LOCK_FILE     = 2'd2;
   localparam logic [1:0] LOCK_NONE     = 2'd3;

   typedef struct {
      mlfw_pkg::status_type       status;
      mlfw_pkg::caller_state_type caller_state;
      logic [7:0]                 new_owner;
      logic                       owner_valid;
   } lock_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [1:0] lock_id, [9:2] pid, rest zero
   logic        req_tuser = 1'b0;  // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [3:0] status, [5:4] caller_state,
                                   // [13:6] new_owner, [14] owner_valid

   // Predicted lock state
   bit         lock_taken [NUM_LOCKS];
   logic [7:0] lock_owner [NUM_LOCKS];
   logic [7:0] lock_waiters [NUM_LOCKS][$];

   lock_outcome_type lock_outcomes [$];
   int unsigned   fail_count = 0;
   bit            sender_idles = 1'b1;
   bit            receiver_idles = 1'b1;
   int unsigned   hold_off_cycles = 0;
   logic [7:0]    pid_pool [12];

   mutex_lock_with_fifo_waiters dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Work out the response to one request and advance the lock state
   function automatic lock_outcome_type resolve_lock_request(logic func, logic [1:0] lock,
                                                             logic [7:0] pid);
      lock_outcome_type out;
      bit queued;
      int idx;
      idx = lock;
      out.caller_state = mlfw_pkg::CS_UNCHANGED;
      out.new_owner = 8'd0;
      out.owner_valid = 1'b0;
      if (lock >= NUM_LOCKS) begin
         out.status = mlfw_pkg::ST_INVALID;
         return out;
      end
      queued = 1'b0;
      foreach (lock_waiters[idx][i]) begin
         if (lock_waiters[idx][i] == pid) queued = 1'b1;
      end
      if (func == mlfw_pkg::FUNC_WAIT) begin
         if (!lock_taken[idx]) begin
            lock_taken[idx] = 1'b1;
            lock_owner[idx] = pid;
            out.status = mlfw_pkg::ST_ACQUIRED;
            out.caller_state = mlfw_pkg::CS_RUNNING;
         end else if (lock_owner[idx] == pid) begin
            out.status = mlfw_pkg::ST_ALREADY_OWNER;
         end else if (queued) begin
            out.status = mlfw_pkg::ST_ALREADY_BLOCKED;
         end else if (lock_waiters[idx].size() >= QUEUE_DEPTH) begin
            out.status = mlfw_pkg::ST_QUEUE_FULL;
         end else begin
            lock_waiters[idx].push_back(pid);
            out.status = mlfw_pkg::ST_BLOCKED;
            out.caller_state = mlfw_pkg::CS_BLOCKED;
         end
      end else begin
         if (!lock_taken[idx]) begin
            out.status = mlfw_pkg::ST_NOT_LOCKED;
         end else if (lock_owner[idx] != pid) begin
            out.status = mlfw_pkg::ST_NOT_OWNER;
         end else if (lock_waiters[idx].size() == 0) begin
            lock_taken[idx] = 1'b0;
            lock_owner[idx] = 8'd0;
            out.status = mlfw_pkg::ST_RELEASED;
            out.caller_state = mlfw_pkg::CS_READY;
         end else begin
            lock_owner[idx] = lock_waiters[idx].pop_front();
            out.status = mlfw_pkg::ST_TRANSFERRED;
            out.caller_state = mlfw_pkg::CS_READY;
         end
      end
      if (lock_taken[idx]) begin
         out.new_owner = lock_owner[idx];
         out.owner_valid = 1'b1;
      end
      return out;
   endfunction

   // Offer one request and hold it until the transfer completes
   task automatic send_request(logic func, logic [1:0] lock, logic [7:0] pid);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'd0, pid, lock};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lock_outcomes.push_back(resolve_lock_request(func, lock, pid));
   endtask

   // Accept responses with random stalls and check each one
   initial begin
      lock_outcome_type want;
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         stall = receiver_idles ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (lock_outcomes.size() == 0) begin
            $display("%0t: response with none expected, rsp_tdata %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = lock_outcomes.pop_front();
            if (rsp_tdata[3:0] !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_tdata[3:0]);
               fail_count++;
            end
            if (rsp_tdata[5:4] !== want.caller_state) begin
               $display("%0t: caller_state expected %0d actual %0d",
                        $time, want.caller_state, rsp_tdata[5:4]);
               fail_count++;
            end
            if (rsp_tdata[13:6] !== want.new_owner) begin
               $display("%0t: new_owner expected %0d actual %0d",
                        $time, want.new_owner, rsp_tdata[13:6]);
               fail_count++;
            end
            if (rsp_tdata[14] !== want.owner_valid) begin
               $display("%0t: owner_valid expected %0d actual %0d",
                        $time, want.owner_valid, rsp_tdata[14]);
               fail_count++;
            end
         end
      end
   end

   // One of each outcome, with pid extremes and a full queue
   task automatic test_directed_cases();
      send_request(mlfw_pkg::FUNC_WAIT, LOCK_NONE, 8'hAA);
      send_request(mlfw_pkg::FUNC_SIGNAL, LOCK_NONE, 8'h55);
      send_request(mlfw_pkg::FUNC_SIGNAL, LOCK_USER_IN, 8'h00);
      send_request(mlfw_pkg::FUNC_WAIT, LOCK_USER_IN, 8'h00);
      send_request(mlfw_pkg::FUNC_WAIT, LOCK_USER_IN, 8'h00);
      send_request(mlfw_pkg::FUNC_WAIT, LOCK_USER_IN, 8'hFF);
      send_request(mlfw_pkg::FUNC_WAIT, LOCK_USER_IN, 8'hFF);
      send_request(mlfw_pkg::FUNC_SIGNAL, LOCK_USER_IN, 8'hFF);
      send_request(mlfw_pkg::FUNC_SIGNAL, LOCK_USER_IN, 8'h00);
      send_request(mlfw_pkg::FUNC_SIGNAL, LOCK_USER_IN, 8'hFF);
      // owner plus eight waiters, then one more is dropped
      for (int p = 1; p <= QUEUE_DEPTH + 2; p++) begin
         send_request(mlfw_pkg::FUNC_WAIT, LOCK_USER_OUT, 8'(p));
      end
      send_request(mlfw_pkg::FUNC_SIGNAL, LOCK_USER_OUT, 8'd1);
      send_request(mlfw_pkg::FUNC_WAIT, LOCK_FILE, 8'h80);
   endtask

   // Owner-aware traffic over a small pool of pids so queues fill and drain
   task automatic test_lock_traffic(int unsigned count);
      int unsigned pick;
      int lk;
      logic [7:0] pid;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 60 == 0) begin
            foreach (pid_pool[i]) pid_pool[i] = 8'($urandom);
         end
         lk = $urandom_range(0, NUM_LOCKS - 1);
         pick = $urandom_range(0, 99);
         pid = pid_pool[$urandom_range(0, 11)];
         if (pick < 42) begin
            send_request(mlfw_pkg::FUNC_WAIT, 2'(lk), pid);
         end else if (pick < 75) begin
            send_request(mlfw_pkg::FUNC_SIGNAL, 2'(lk),
                         lock_taken[lk] ? lock_owner[lk] : pid);
         end else if (pick < 84) begin
            send_request(mlfw_pkg::FUNC_SIGNAL, 2'(lk), pid);
         end else if (pick < 92) begin
            if (lock_waiters[lk].size() > 0 && pick[0])
               pid = lock_waiters[lk][$urandom_range(0, lock_waiters[lk].size() - 1)];
            else if (lock_taken[lk])
               pid = lock_owner[lk];
            send_request(mlfw_pkg::FUNC_WAIT, 2'(lk), pid);
         end else begin
            // noise: any lock id, any pid
            send_request(1'($urandom), 2'($urandom), 8'($urandom));
         end
      end
   endtask

   // Hold responses off while requests keep coming
   task automatic test_response_backpressure();
      sender_idles = 1'b0;
      hold_off_cycles = 200;
      test_lock_traffic(30);
      sender_idles = 1'b1;
   endtask

   // Drain outstanding responses and report
   task automatic finish_run();
      int unsigned waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (lock_outcomes.size() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (lock_outcomes.size() > 0) begin
         $display("%0t: %0d responses never arrived", $time, lock_outcomes.size());
         fail_count++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_lock_traffic(300);
      test_response_backpressure();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      test_lock_traffic(250);
      finish_run();
      if (fail_count == 0) begin
         $display("mutex_lock_with_fifo_waiters regression: pass");
      end else begin
         $display("mutex_lock_with_fifo_waiters regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("mutex_lock_with_fifo_waiters regression: fail");
      $finish;
   end

endmodule
